[rtl/smpq_pkg.sv]
// Shared types and constants for the sorted min priority queue.
// Holds field widths, operation and status codes, and the sequencer state type.
// No dependencies.
package smpq_pkg;

    // Fixed field widths of the stream beats
    localparam int TAG_W     = 9;
    localparam int PRIO_IN_W = 24;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 40;   // priority_req + tag, padded to bytes
    localparam int M_FIXED_W = 35;   // status + out_priority + out_tag

    // Operation codes carried in s_tuser
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_INS,
        ST_DONE
    } smpq_state_t;

endpackage

[rtl/smpq_mem.sv]
// Entry store of the priority queue: one write port, one read port,
// registered read data. Depends on nothing.
module smpq_mem #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 33
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/smpq_ctrl.sv]
// Sequencer of the priority queue: circular sorted list in smpq_mem, insertion
// by a backward scan that shifts larger entries up, pop by moving the head.
// Depends on smpq_pkg.
module smpq_ctrl #(
    parameter int DEPTH     = 512,
    parameter int PRIO_BITS = 24,
    parameter int LVL_W     = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input beat
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_func,
    input  logic [smpq_pkg::PRIO_IN_W-1:0]      in_prio,
    input  logic [smpq_pkg::TAG_W-1:0]          in_tag,
    // result beat
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [smpq_pkg::STATUS_W-1:0]       out_status,
    output logic [smpq_pkg::PRIO_IN_W-1:0]      out_prio,
    output logic [smpq_pkg::TAG_W-1:0]          out_tag,
    output logic [LVL_W-1:0]                    out_level,
    // entry store
    output logic                                wr_en,
    output logic [$clog2(DEPTH)-1:0]            wr_addr,
    output logic [PRIO_BITS+smpq_pkg::TAG_W-1:0] wr_data,
    output logic                                rd_en,
    output logic [$clog2(DEPTH)-1:0]            rd_addr,
    input  logic [PRIO_BITS+smpq_pkg::TAG_W-1:0] rd_data
);

    import smpq_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ENT_W  = PRIO_BITS + TAG_W;
    localparam logic [ADDR_W:0]  DEPTH_A = (ADDR_W+1)'(DEPTH);
    localparam logic [LVL_W-1:0] DEPTH_L = LVL_W'(DEPTH);

    smpq_state_t state_reg, state_next;
    logic [LVL_W-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0]    head_reg, head_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic                 op_reg, op_next;
    logic [PRIO_BITS-1:0] prio_reg, prio_next;
    logic [TAG_W-1:0]     tag_reg, tag_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [PRIO_BITS-1:0] res_prio_reg, res_prio_next;
    logic [TAG_W-1:0]     res_tag_reg, res_tag_next;

    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [PRIO_IN_W-1:0] m_prio_reg, m_prio_next;
    logic [TAG_W-1:0]     m_tag_reg, m_tag_next;
    logic [LVL_W-1:0]     m_level_reg, m_level_next;

    logic [PRIO_BITS-1:0] in_prio_cut;
    logic [PRIO_BITS-1:0] rd_prio;
    logic [TAG_W-1:0]     rd_tag;
    logic                 shift;
    logic [ADDR_W-1:0]    idx_inc;
    logic                 out_free;

    // Map a logical slot (0 = head) onto a memory address
    function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] head,
                                                input logic [ADDR_W-1:0] slot);
        logic [ADDR_W:0] sum;
        sum = {1'b0, head} + {1'b0, slot};
        if (sum >= DEPTH_A) begin
            sum = sum - DEPTH_A;
        end
        return sum[ADDR_W-1:0];
    endfunction

    // Keep only the low PRIO_BITS of the requested frequency
    assign in_prio_cut = PRIO_BITS'(32'(in_prio));

    assign rd_prio  = rd_data[ENT_W-1:TAG_W];
    assign rd_tag   = rd_data[TAG_W-1:0];
    assign idx_inc  = idx_reg + ADDR_W'(1);
    assign out_free = !m_valid_reg || out_ready;

    // Move the stored entry up unless the new one belongs above it; at the head
    // only a strictly smaller frequency goes in front
    assign shift = (idx_reg == '0) ? (rd_prio > prio_reg) : (rd_prio >= prio_reg);

    assign in_ready = (state_reg == ST_IDLE);

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        op_reg         <= op_next;
        prio_reg       <= prio_next;
        tag_reg        <= tag_next;
        res_status_reg <= res_status_next;
        res_prio_reg   <= res_prio_next;
        res_tag_reg    <= res_tag_next;
        m_status_reg   <= m_status_next;
        m_prio_reg     <= m_prio_next;
        m_tag_reg      <= m_tag_next;
        m_level_reg    <= m_level_next;
    end

    // Next state, memory accesses and results
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        prio_next       = prio_reg;
        tag_next        = tag_reg;
        res_status_next = res_status_reg;
        res_prio_next   = res_prio_reg;
        res_tag_next    = res_tag_reg;
        m_valid_next    = m_valid_reg && !out_ready;
        m_status_next   = m_status_reg;
        m_prio_next     = m_prio_reg;
        m_tag_next      = m_tag_reg;
        m_level_next    = m_level_reg;
        wr_en           = 1'b0;
        wr_addr         = phys(head_reg, idx_inc);
        wr_data         = {prio_reg, tag_reg};
        rd_en           = 1'b0;
        rd_addr         = phys(head_reg, idx_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op_next         = in_func;
                    prio_next       = in_prio_cut;
                    tag_next        = in_tag;
                    res_status_next = STATUS_OK;
                    res_prio_next   = '0;
                    res_tag_next    = '0;
                    if (in_func == FUNC_PUSH) begin
                        if (count_reg == DEPTH_L) begin
                            res_status_next = STATUS_FULL;
                            state_next      = ST_DONE;
                        end else if (count_reg == '0) begin
                            // empty list: place the entry at the head at once
                            wr_en      = 1'b1;
                            wr_addr    = head_reg;
                            wr_data    = {in_prio_cut, in_tag};
                            count_next = count_reg + LVL_W'(1);
                            state_next = ST_DONE;
                        end else begin
                            // scan back from the tail
                            idx_next   = ADDR_W'(count_reg - LVL_W'(1));
                            state_next = ST_READ;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_status_next = STATUS_EMPTY;
                            state_next      = ST_DONE;
                        end else begin
                            idx_next   = '0;
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                rd_en      = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (op_reg == FUNC_POP) begin
                    // hand out the head and advance it
                    res_prio_next = rd_prio;
                    res_tag_next  = rd_tag;
                    head_next     = phys(head_reg, ADDR_W'(1));
                    count_next    = count_reg - LVL_W'(1);
                    state_next    = ST_DONE;
                end else if (shift) begin
                    // move the larger entry one slot toward the tail
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    if (idx_reg == '0) begin
                        state_next = ST_INS;
                    end else begin
                        idx_next   = idx_reg - ADDR_W'(1);
                        state_next = ST_READ;
                    end
                end else begin
                    // slot found just above this entry
                    wr_en      = 1'b1;
                    count_next = count_reg + LVL_W'(1);
                    state_next = ST_DONE;
                end
            end
            ST_INS: begin
                wr_en      = 1'b1;
                wr_addr    = head_reg;
                count_next = count_reg + LVL_W'(1);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_prio_next   = PRIO_IN_W'(32'(res_prio_reg));
                    m_tag_next    = res_tag_reg;
                    m_level_next  = count_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid  = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_prio   = m_prio_reg;
    assign out_tag    = m_tag_reg;
    assign out_level  = m_level_reg;

endmodule

[rtl/sorted_min_priority_queue.sv]
// Sorted min priority queue: push places an entry in frequency order, pop returns the head.
// A refused beat or a push into an empty queue goes straight to the result; a pop reads and
// hands out the head; a push reads and compares each stored entry from the tail (one memory
// read and one compare per entry on the single read port), shifting larger ones up, until its slot is found.
// One beat in flight; the next beat is taken the cycle after the result enters the output register.
// Reset (aresetn low, synchronous) empties the queue; memory contents stay undefined.
module sorted_min_priority_queue #(
    parameter int DEPTH     = 512,
    parameter int PRIO_BITS = 24,
    localparam int LVL_W     = $clog2(DEPTH + 1),
    localparam int M_TDATA_W = ((smpq_pkg::M_FIXED_W + LVL_W + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [smpq_pkg::S_TDATA_W-1:0] s_tdata,  // priority_req[23:0], tag[32:24], zero pad
    input  logic                           s_tuser,  // func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [M_TDATA_W-1:0]           m_tdata   // status, out_priority, out_tag, level, pad
);

    import smpq_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ENT_W  = PRIO_BITS + TAG_W;
    localparam int PAD_W  = M_TDATA_W - M_FIXED_W - LVL_W;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ENT_W-1:0]     wr_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ENT_W-1:0]     rd_data;
    logic [STATUS_W-1:0]  out_status;
    logic [PRIO_IN_W-1:0] out_prio;
    logic [TAG_W-1:0]     out_tag;
    logic [LVL_W-1:0]     out_level;

    smpq_ctrl #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS),
        .LVL_W     (LVL_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tuser),
        .in_prio    (s_tdata[PRIO_IN_W-1:0]),
        .in_tag     (s_tdata[PRIO_IN_W+TAG_W-1:PRIO_IN_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_prio   (out_prio),
        .out_tag    (out_tag),
        .out_level  (out_level),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    smpq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (ENT_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Pack the result beat, status in the lowest bits
    assign m_tdata = {PAD_W'(0), out_level, out_tag, out_prio, out_status};

endmodule

[rtl/smpq_checker.sv]
// Port-level checks for the sorted min priority queue, bound to the top level.
// Depends on smpq_pkg and sorted_min_priority_queue.
module smpq_checker #(
    parameter int DEPTH     = 512,
    parameter int M_TDATA_W = 48
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [M_TDATA_W-1:0]           m_tdata
);

    import smpq_pkg::*;

    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [STATUS_W-1:0]  res_status;
    logic [PRIO_IN_W-1:0] res_prio;
    logic [TAG_W-1:0]     res_tag;
    logic [LVL_W-1:0]     res_level;

    assign res_status = m_tdata[STATUS_W-1:0];
    assign res_prio   = m_tdata[STATUS_W+PRIO_IN_W-1:STATUS_W];
    assign res_tag    = m_tdata[M_FIXED_W-1:STATUS_W+PRIO_IN_W];
    assign res_level  = m_tdata[M_FIXED_W+LVL_W-1:M_FIXED_W];

    // Hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Drop any result after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Fill level stays within the store
    a_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res_level <= LVL_W'(DEPTH))
        else $error("level exceeds depth");

    // Refused beats carry no entry, and a refusal reports a full or an empty queue
    a_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_status != STATUS_OK |-> res_prio == '0 && res_tag == '0)
        else $error("refused beat carries entry data");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_status == STATUS_OK)
                  || (res_status == STATUS_FULL && res_level == LVL_W'(DEPTH))
                  || (res_status == STATUS_EMPTY && res_level == '0))
        else $error("status disagrees with level");

endmodule

bind sorted_min_priority_queue smpq_checker #(
    .DEPTH     (DEPTH),
    .M_TDATA_W (M_TDATA_W)
) u_smpq_checker (.*);

[dv/sorted_min_priority_queue_tb.sv]
// Self-checking testbench for the sorted min priority queue.
// Drives push and pop beats under bursty input and stalling output, predicts each
// result from a shadow queue kept in order. Depends on smpq_pkg and the RTL top.
module sorted_min_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smpq_pkg::*;

    localparam int DEPTH        = 512;
    localparam int PRIO_BITS    = 24;
    localparam int LVL_W        = $clog2(DEPTH + 1);
    localparam int M_TDATA_W    = ((M_FIXED_W + LVL_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 300;
    localparam int STALL_LIMIT  = 10000;
    localparam int END_CYCLES   = 16;
    localparam int MAX_REPORTS  = 50;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [PRIO_IN_W-1:0] prio;
        logic [TAG_W-1:0]     tag;
        logic [LVL_W-1:0]     level;
    } queue_result_t;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;  // priority_req[23:0], tag[32:24], zero pad
    logic                   s_tuser  = 1'b0;  // func
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;  // status, out_priority, out_tag, level, zero pad

    // Shadow copy of the queue contents, ascending by frequency
    logic [PRIO_BITS-1:0]   shadow_prio[$];
    logic [TAG_W-1:0]       shadow_tag[$];
    queue_result_t          pending_results[$];

    int       errors       = 0;
    int       burst_left   = 0;
    int       no_gap_items = 0;
    int       rx_hold      = 0;
    int       rx_mode_left = 0;
    int       stall_cycles = 0;
    rx_mode_t rx_mode      = RX_OPEN;

    sorted_min_priority_queue #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Apply one accepted operation to the shadow queue and record its result
    task automatic predict_queue_op(input logic func, input logic [PRIO_IN_W-1:0] prio_in,
                                    input logic [TAG_W-1:0] tag_in);
        queue_result_t        res;
        logic [PRIO_BITS-1:0] p;
        int                   slot;
        res = '0;
        p = prio_in[PRIO_BITS-1:0];
        if (func == FUNC_PUSH) begin
            if (shadow_prio.size() >= DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                // A tie with the head lands behind it; elsewhere ahead of the first tie
                if (shadow_prio.size() == 0 || shadow_prio[0] > p) begin
                    slot = 0;
                end else begin
                    slot = 1;
                    while (slot < shadow_prio.size() && shadow_prio[slot] < p)
                        slot++;
                end
                shadow_prio.insert(slot, p);
                shadow_tag.insert(slot, tag_in);
            end
        end else begin
            if (shadow_prio.size() == 0) begin
                res.status = STATUS_EMPTY;
            end else begin
                res.status = STATUS_OK;
                res.prio   = PRIO_IN_W'(shadow_prio.pop_front());
                res.tag    = shadow_tag.pop_front();
            end
        end
        res.level = LVL_W'(shadow_prio.size());
        pending_results.push_back(res);
    endtask

    // Offer one beat, with a random gap at the start of each burst
    task automatic send_item(input logic func, input logic [PRIO_IN_W-1:0] prio,
                             input logic [TAG_W-1:0] tag);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (no_gap_items > 0) ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        if (no_gap_items > 0)
            no_gap_items--;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{(S_TDATA_W - PRIO_IN_W - TAG_W){1'b0}}, tag, prio};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_queue_op(func, prio, tag);
    endtask

    // Drop valid and hold until every owed result has been seen
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] beat);
        queue_result_t got;
        queue_result_t want;
        got.status = beat[STATUS_W-1:0];
        got.prio   = beat[STATUS_W +: PRIO_IN_W];
        got.tag    = beat[STATUS_W + PRIO_IN_W +: TAG_W];
        got.level  = beat[M_FIXED_W +: LVL_W];
        if (pending_results.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: unexpected result, expected none actual %0h", $time, got);
        end else begin
            want = pending_results.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("out_priority", 32'(want.prio), 32'(got.prio));
            compare_field("out_tag", 32'(want.tag), 32'(got.tag));
            compare_field("level", 32'(want.level), 32'(got.level));
        end
    endtask

    // Check each result beat, then pick the next ready value
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_result(m_tdata);
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(8, 200);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
                default:   m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // End the run when no beat moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Extremes of every field, ties at the head, in the middle and at the tail
    task automatic test_directed();
        send_item(FUNC_POP, '0, '0);
        send_item(FUNC_PUSH, 24'hFFFFFF, 9'h1FF);
        send_item(FUNC_PUSH, 24'h000000, 9'h000);
        send_item(FUNC_PUSH, 24'h000000, 9'h005);
        send_item(FUNC_PUSH, 24'h800000, 9'h100);
        send_item(FUNC_PUSH, 24'h800000, 9'h0AA);
        send_item(FUNC_PUSH, 24'hFFFFFF, 9'h055);
        send_item(FUNC_PUSH, 24'h000001, 9'h001);
        repeat (8) send_item(FUNC_POP, '0, '0);
        send_item(FUNC_POP, 24'hFFFFFF, 9'h1FF);
        wait_drained();
    endtask

    // Fill to capacity in falling order while the output holds off, then push while full
    task automatic test_fill_to_full();
        logic [PRIO_IN_W-1:0] p;
        p = 24'hFFFF00;
        rx_hold = 500;
        no_gap_items = 60;
        for (int i = 0; i < DEPTH; i++) begin
            if (i % 8 != 7)
                p = 24'hFFFF00 - PRIO_IN_W'(i * 7);
            send_item(FUNC_PUSH, p, 9'($urandom));
        end
        send_item(FUNC_PUSH, 24'h000000, 9'h000);
        send_item(FUNC_PUSH, 24'hFFFFFF, 9'h1FF);
        send_item(FUNC_PUSH, 24'($urandom), 9'($urandom));
        wait_drained();
    endtask

    // Insert past nearly every stored entry, then refill to full
    task automatic test_deep_insert();
        repeat (3) send_item(FUNC_POP, 24'($urandom), 9'($urandom));
        send_item(FUNC_PUSH, 24'hFFFFFF, 9'h0F0);
        send_item(FUNC_PUSH, PRIO_IN_W'(shadow_prio[200]), 9'h10F);
        send_item(FUNC_PUSH, 24'h000000, 9'h1FF);
        send_item(FUNC_PUSH, 24'h7FFFFF, 9'h000);
        wait_drained();
    endtask

    // Random mix steered around a moving fill target
    task automatic test_random_mix();
        int                   target;
        int                   lvl;
        logic                 func;
        logic [PRIO_IN_W-1:0] p;
        target = 8;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0)
                target = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 16);
            if (n == 150)
                no_gap_items = 80;
            lvl = shadow_prio.size();
            if (lvl < target)
                func = ($urandom_range(0, 3) != 0) ? FUNC_PUSH : FUNC_POP;
            else
                func = ($urandom_range(0, 3) == 0) ? FUNC_PUSH : FUNC_POP;
            case ($urandom_range(0, 3))
                0: p = PRIO_IN_W'($urandom_range(0, 7));
                1: p = PRIO_IN_W'($urandom);
                2: p = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
                default: p = (lvl > 0) ? PRIO_IN_W'(shadow_prio[$urandom_range(0, lvl - 1)])
                                       : PRIO_IN_W'($urandom);
            endcase
            send_item(func, p, 9'($urandom));
        end
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_fill_to_full();
        test_deep_insert();
        test_random_mix();
        repeat (END_CYCLES) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
